[rtl/core/bm3_pkg.sv]
// ---------------------------------------------------------------------------
// bm3_pkg
// Shared widths, types and constants of the 3x3 border-aware box mean core.
// ---------------------------------------------------------------------------
package bm3_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int POS_BITS       = 10;
	localparam int REG_BITS       = 11;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_COL_COUNT = CFG_INDEX_BITS'(1);

	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 1024;

	// Sum of three samples, sum of nine samples, magnitude of a nine-sample sum.
	localparam int COLSUM_BITS = SAMPLE_BITS + 2;
	localparam int SUM_BITS    = SAMPLE_BITS + 4;
	localparam int MAG_BITS    = SAMPLE_BITS + 3;

	localparam logic [MAG_BITS-1:0] RECIP_THREE = MAG_BITS'((64'd1 << MAG_BITS) / 3);
	localparam logic [MAG_BITS-1:0] RECIP_NINE  = MAG_BITS'((64'd1 << MAG_BITS) / 9);

	localparam int OUT_DATA_BITS = ((2 * POS_BITS + SAMPLE_BITS + 7) / 8) * 8;

	// Bits of the pending-result mask, in row-major emit order.
	localparam int RES_UP_LEFT = 0;
	localparam int RES_UP      = 1;
	localparam int RES_LEFT    = 2;
	localparam int RES_HERE    = 3;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] top;
		logic signed [SAMPLE_BITS-1:0] mid;
		logic signed [SAMPLE_BITS-1:0] bot;
	} win_col_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] above;
		logic [SAMPLE_BITS-1:0] two_above;
	} line_ent_t;

	typedef struct packed {
		logic [POS_BITS-1:0] row;
		logic [POS_BITS-1:0] col;
		logic                last;
	} res_tag_t;

	typedef enum logic [1:0] {
		BASE_ONE,
		BASE_THREE,
		BASE_NINE
	} base_t;

endpackage

[rtl/core/bm3_line_buf.sv]
// ---------------------------------------------------------------------------
// bm3_line_buf
// Line store for the two rows above the current one, one entry per column,
// with a registered read port and write-to-read forwarding.
// ---------------------------------------------------------------------------
module bm3_line_buf import bm3_pkg::*; #(
	parameter int DEPTH = MAX_COLS_DEF,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output line_ent_t            rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  line_ent_t            wr_data
);

	line_ent_t mem_q [DEPTH];
	line_ent_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// A single-column frame reads the entry that is written in the same cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule

[rtl/core/bm3_col_cell.sv]
// ---------------------------------------------------------------------------
// bm3_col_cell
// One column of the 3x3 window: holds three samples, passes them to its
// neighbor on a shift and gives the sum of the selected rows.
// ---------------------------------------------------------------------------
module bm3_col_cell import bm3_pkg::*; (
	input  logic                          clk,
	input  logic                          shift,
	input  win_col_t                      col_in,
	output win_col_t                      col_out,
	input  logic [2:0]                    row_sel,
	output logic signed [COLSUM_BITS-1:0] col_sum
);

	win_col_t col_q;
	logic signed [COLSUM_BITS-1:0] top_x;
	logic signed [COLSUM_BITS-1:0] mid_x;
	logic signed [COLSUM_BITS-1:0] bot_x;

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	always_comb begin
		top_x   = row_sel[0] ? COLSUM_BITS'(col_q.top) : '0;
		mid_x   = row_sel[1] ? COLSUM_BITS'(col_q.mid) : '0;
		bot_x   = row_sel[2] ? COLSUM_BITS'(col_q.bot) : '0;
		col_sum = top_x + mid_x + bot_x;
	end

endmodule

[rtl/core/bm3_mean_div.sv]
// ---------------------------------------------------------------------------
// bm3_mean_div
// Four-stage elastic pipeline: adds three column sums and divides by the
// neighbor count (1, 2, 3, 4, 6 or 9), truncating toward zero.
// ---------------------------------------------------------------------------
module bm3_mean_div import bm3_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COLSUM_BITS-1:0] col_sum [3],
	input  logic [1:0]                    row_n,
	input  logic [1:0]                    col_n,
	input  res_tag_t                      in_tag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [SAMPLE_BITS-1:0]        out_mean,
	output res_tag_t                      out_tag
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic go1, go2, go3, go4;

	logic signed [COLSUM_BITS-1:0] cs_s1 [3];
	logic [1:0]                    rn_s1, cn_s1;
	res_tag_t                      tag_s1;

	logic [MAG_BITS-1:0] mag_s2;
	base_t               base_s2;
	logic                neg_s2;
	res_tag_t            tag_s2;

	logic [2*MAG_BITS-1:0] prod_s3;
	logic [MAG_BITS-1:0]   mag_s3;
	base_t                 base_s3;
	logic                  neg_s3;
	res_tag_t              tag_s3;

	logic [SAMPLE_BITS-1:0] mean_s4;
	res_tag_t               tag_s4;

	logic signed [SUM_BITS-1:0] sum;
	logic [SUM_BITS-1:0]        abs_sum;
	logic [3:0]                 cnt;
	logic [1:0]                 sh;
	base_t                      base;
	logic [MAG_BITS-1:0]        recip;
	logic [MAG_BITS-1:0]        q0, qc;
	logic [MAG_BITS+3:0]        q0_x, qd, rem, dv;
	logic [SAMPLE_BITS-1:0]     qt;

	assign go4      = valid_s3 && (!valid_s4 || out_ready);
	assign go3      = valid_s2 && (!valid_s3 || go4);
	assign go2      = valid_s1 && (!valid_s2 || go3);
	assign in_ready = !valid_s1 || go2;
	assign go1      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (go1) begin
				valid_s1 <= 1'b1;
			end else if (go2) begin
				valid_s1 <= 1'b0;
			end
			if (go2) begin
				valid_s2 <= 1'b1;
			end else if (go3) begin
				valid_s2 <= 1'b0;
			end
			if (go3) begin
				valid_s3 <= 1'b1;
			end else if (go4) begin
				valid_s3 <= 1'b0;
			end
			if (go4) begin
				valid_s4 <= 1'b1;
			end else if (out_ready) begin
				valid_s4 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			for (int k = 0; k < 3; k++) begin
				cs_s1[k] <= col_sum[k];
			end
			rn_s1  <= row_n;
			cn_s1  <= col_n;
			tag_s1 <= in_tag;
		end
	end

	// Divisors with a factor of two are shifted first, leaving 1, 3 or 9.
	always_comb begin
		sum     = SUM_BITS'(cs_s1[0]) + SUM_BITS'(cs_s1[1]) + SUM_BITS'(cs_s1[2]);
		abs_sum = sum[SUM_BITS-1] ? -sum : sum;
		cnt     = {2'b00, rn_s1} * {2'b00, cn_s1};
		sh      = 2'd0;
		base    = BASE_ONE;
		case (cnt)
			4'd2: begin
				sh = 2'd1;
			end
			4'd3: begin
				base = BASE_THREE;
			end
			4'd4: begin
				sh = 2'd2;
			end
			4'd6: begin
				sh   = 2'd1;
				base = BASE_THREE;
			end
			4'd9: begin
				base = BASE_NINE;
			end
			default: begin
				sh   = 2'd0;
				base = BASE_ONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (go2) begin
			mag_s2  <= MAG_BITS'(abs_sum) >> sh;
			base_s2 <= base;
			neg_s2  <= sum[SUM_BITS-1];
			tag_s2  <= tag_s1;
		end
	end

	assign recip = (base_s2 == BASE_THREE) ? RECIP_THREE : RECIP_NINE;

	always_ff @(posedge clk) begin
		if (go3) begin
			prod_s3 <= (2*MAG_BITS)'(mag_s2) * (2*MAG_BITS)'(recip);
			mag_s3  <= mag_s2;
			base_s3 <= base_s2;
			neg_s3  <= neg_s2;
			tag_s3  <= tag_s2;
		end
	end

	// The reciprocal estimate is low by at most one; the remainder fixes it.
	always_comb begin
		q0   = (base_s3 == BASE_ONE) ? mag_s3 : prod_s3[2*MAG_BITS-1:MAG_BITS];
		q0_x = (MAG_BITS+4)'(q0);
		case (base_s3)
			BASE_NINE: begin
				qd = (q0_x << 3) + q0_x;
				dv = (MAG_BITS+4)'(9);
			end
			BASE_THREE: begin
				qd = (q0_x << 1) + q0_x;
				dv = (MAG_BITS+4)'(3);
			end
			default: begin
				qd = q0_x;
				dv = (MAG_BITS+4)'(1);
			end
		endcase
		rem = (MAG_BITS+4)'(mag_s3) - qd;
		qc  = (rem >= dv) ? (q0 + 1'b1) : q0;
		qt  = SAMPLE_BITS'(qc);
	end

	always_ff @(posedge clk) begin
		if (go4) begin
			mean_s4 <= neg_s3 ? -qt : qt;
			tag_s4  <= tag_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_mean  = mean_s4;
	assign out_tag   = tag_s4;

endmodule

[rtl/core/box_mean_3x3_border_count_core.sv]
// ---------------------------------------------------------------------------
// box_mean_3x3_border_count_core
// A sample word is registered, enters the window, and its results pass the
// divider pipeline. Throughput: one word per cycle in and out while the output
// is not stalled and each sample gives at most one result; the window sequencer
// issues one result per cycle while the divider takes them, so a sample with two
// results (a row end, or a sample on the last row) and the frame's last sample
// hold the input back. Reset clears all control state and sets one row by one
// column; the line store is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module box_mean_3x3_border_count_core import bm3_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [SAMPLE_BITS-1:0]    s_axis_tdata,   // sample
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,   // out_row, out_col, mean, zero fill
	output logic                      m_axis_tlast,   // frame_last
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [REG_BITS-1:0]       cfg_data
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [RW-1:0] last_row_q, row_q, row_s1, win_row_q;
	logic [CW-1:0] last_col_q, col_q, col_s1, win_col_q;
	logic [RW-1:0] lim_row;
	logic [CW-1:0] lim_col;
	logic          cfg_hit;

	logic                   in_fire;
	logic                   vld_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic [3:0]             pend_s1;
	logic                   row_end, last_row;

	line_ent_t rd_ent, wr_ent;
	win_col_t  new_col;
	win_col_t  col_01, col_12;
	logic signed [COLSUM_BITS-1:0] cell_sum [3];
	logic signed [COLSUM_BITS-1:0] div_cs [3];

	logic [3:0] pend_q, pick, pend_left;
	logic       ro, co;
	logic [2:0] row_sel, col_sel;
	logic [1:0] row_n, col_n;
	res_tag_t   iss_tag, out_tag;
	logic       iss_valid, iss_go, div_ready, chain_ready, s1_go;
	logic [SAMPLE_BITS-1:0] out_mean;

	// Configuration: counts are kept as the index of the last row and column.
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && ((cfg_index == REG_ROW_COUNT) ||
		(cfg_index == REG_COL_COUNT));

	always_comb begin
		if (cfg_data == '0) begin
			lim_row = '0;
			lim_col = '0;
		end else begin
			lim_row = (int'(cfg_data) > MAX_ROWS) ? RW'(MAX_ROWS - 1) : RW'(cfg_data - 1'b1);
			lim_col = (int'(cfg_data) > MAX_COLS) ? CW'(MAX_COLS - 1) : CW'(cfg_data - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_row_q <= '0;
			last_col_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW_COUNT: begin
					last_row_q <= lim_row;
				end
				REG_COL_COUNT: begin
					last_col_q <= lim_col;
				end
				default: begin
				end
			endcase
		end
	end

	// Input side: position counters and the line-store read stage.
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !vld_s1 || s1_go;
	assign row_end       = (col_q == last_col_q);
	assign last_row      = (row_q == last_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : (row_q + 1'b1);
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_fire) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			smp_s1                <= s_axis_tdata;
			row_s1                <= row_q;
			col_s1                <= col_q;
			pend_s1[RES_UP_LEFT]  <= (row_q != '0) && (col_q != '0);
			pend_s1[RES_UP]       <= (row_q != '0) && row_end;
			pend_s1[RES_LEFT]     <= last_row && (col_q != '0);
			pend_s1[RES_HERE]     <= last_row && row_end;
		end
	end

	always_comb begin
		wr_ent.above     = smp_s1;
		wr_ent.two_above = rd_ent.above;
		new_col.top      = rd_ent.two_above;
		new_col.mid      = rd_ent.above;
		new_col.bot      = smp_s1;
	end

	bm3_line_buf #(
		.DEPTH(MAX_COLS)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (in_fire),
		.rd_addr (col_q),
		.rd_data (rd_ent),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_data (wr_ent)
	);

	// Window: three column cells, the newest column enters at cell 2.
	bm3_col_cell u_cell2 (
		.clk     (clk),
		.shift   (s1_go),
		.col_in  (new_col),
		.col_out (col_12),
		.row_sel (row_sel),
		.col_sum (cell_sum[2])
	);

	bm3_col_cell u_cell1 (
		.clk     (clk),
		.shift   (s1_go),
		.col_in  (col_12),
		.col_out (col_01),
		.row_sel (row_sel),
		.col_sum (cell_sum[1])
	);

	bm3_col_cell u_cell0 (
		.clk     (clk),
		.shift   (s1_go),
		.col_in  (col_01),
		.col_out (),
		.row_sel (row_sel),
		.col_sum (cell_sum[0])
	);

	// Result sequencer: issues the pending results of the window in row-major
	// order. The window takes the next sample once nothing is left pending.
	always_comb begin
		pick = '0;
		if (pend_q[RES_UP_LEFT]) begin
			pick[RES_UP_LEFT] = 1'b1;
		end else if (pend_q[RES_UP]) begin
			pick[RES_UP] = 1'b1;
		end else if (pend_q[RES_LEFT]) begin
			pick[RES_LEFT] = 1'b1;
		end else if (pend_q[RES_HERE]) begin
			pick[RES_HERE] = 1'b1;
		end
	end

	// Results on the current row look one row lower in the window, results
	// at the row end one column further right; that row or column is outside.
	always_comb begin
		ro         = pick[RES_LEFT] | pick[RES_HERE];
		co         = pick[RES_UP] | pick[RES_HERE];
		row_sel[0] = !ro && (win_row_q > RW'(1));
		row_sel[1] = (win_row_q != '0);
		row_sel[2] = 1'b1;
		col_sel[0] = !co && (win_col_q > CW'(1));
		col_sel[1] = (win_col_q != '0);
		col_sel[2] = 1'b1;
		row_n      = {1'b0, row_sel[0]} + {1'b0, row_sel[1]} + {1'b0, row_sel[2]};
		col_n      = {1'b0, col_sel[0]} + {1'b0, col_sel[1]} + {1'b0, col_sel[2]};
		iss_tag.row  = POS_BITS'(ro ? win_row_q : (win_row_q - RW'(1)));
		iss_tag.col  = POS_BITS'(co ? win_col_q : (win_col_q - CW'(1)));
		iss_tag.last = pick[RES_HERE];
		for (int k = 0; k < 3; k++) begin
			div_cs[k] = col_sel[k] ? cell_sum[k] : '0;
		end
	end

	assign iss_valid   = (pend_q != '0);
	assign iss_go      = iss_valid && div_ready;
	assign pend_left   = iss_go ? (pend_q & ~pick) : pend_q;
	assign chain_ready = (pend_left == '0);
	assign s1_go       = vld_s1 && chain_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (s1_go) begin
			pend_q <= pend_s1;
		end else begin
			pend_q <= pend_left;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			win_row_q <= row_s1;
			win_col_q <= col_s1;
		end
	end

	bm3_mean_div u_mean_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (iss_valid),
		.in_ready  (div_ready),
		.col_sum   (div_cs),
		.row_n     (row_n),
		.col_n     (col_n),
		.in_tag    (iss_tag),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_mean  (out_mean),
		.out_tag   (out_tag)
	);

	assign m_axis_tdata = OUT_DATA_BITS'({out_mean, out_tag.col, out_tag.row});
	assign m_axis_tlast = out_tag.last;

	// The last word of a frame is the bottom-right position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		((m_axis_tdata[POS_BITS-1:0] == POS_BITS'(last_row_q)) &&
		(m_axis_tdata[2*POS_BITS-1:POS_BITS] == POS_BITS'(last_col_q))))
		else $error("frame end word is not at the last row and column");

	// A waiting sample never stalls behind an empty window.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (pend_q == '0)) |-> s1_go)
		else $error("window did not take a sample with no results pending");

	// Every result lies inside the configured frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		((32'(m_axis_tdata[POS_BITS-1:0]) <= 32'(last_row_q)) &&
		(32'(m_axis_tdata[2*POS_BITS-1:POS_BITS]) <= 32'(last_col_q))))
		else $error("result position outside the frame");

endmodule
